// File: hw/rtl/ipsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipsl_pkg;

	// fixed point: fraction bits of gains and accumulator
	localparam int FRAC_BITS = 8;

	// field and datapath widths
	localparam int IN_W    = 16;                 // setpoint, measurement
	localparam int GAIN_W  = 16;                 // kp, ki, kd
	localparam int MAG_W   = 15;                 // out_max, i_limit
	localparam int SEP_W   = 16;                 // separation threshold
	localparam int ERR_W   = IN_W + 1;           // error
	localparam int D1_W    = ERR_W + 1;          // e - e1
	localparam int D2_W    = ERR_W + 2;          // e - 2*e1 + e2
	localparam int PI_W    = GAIN_W + ERR_W;     // ki product
	localparam int PP_W    = GAIN_W + D1_W;      // kp product
	localparam int PD_W    = GAIN_W + D2_W;      // kd product
	localparam int INC_W   = PD_W + 2;           // sum of three terms
	localparam int SUM_W   = INC_W + 1;          // accumulator plus increment
	localparam int LIM_W   = MAG_W + FRAC_BITS;  // limit in fixed point
	localparam int ACC_W   = IN_W + FRAC_BITS;   // output accumulator
	localparam int DRIVE_W = IN_W;               // drive output

	// register port
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_KP      = reg_idx_t'(0);
	localparam reg_idx_t REG_KI      = reg_idx_t'(1);
	localparam reg_idx_t REG_KD      = reg_idx_t'(2);
	localparam reg_idx_t REG_OUT_MAX = reg_idx_t'(3);
	localparam reg_idx_t REG_I_SEP   = reg_idx_t'(4);
	localparam reg_idx_t REG_I_LIMIT = reg_idx_t'(5);

	// reset values of the limit registers
	localparam logic [MAG_W-1:0] OUT_MAX_RST = {MAG_W{1'b1}};
	localparam logic [MAG_W-1:0] I_LIMIT_RST = {MAG_W{1'b1}};

endpackage

`default_nettype wire

// File: hw/rtl/incremental_pid_speed_loop_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                       Word
// -------   ---  ------------------------------  -------------------------
// in        in   in_valid / in_ready             setpoint, measurement
// out       out  out_valid / out_ready           drive, saturated
// cfg       in   psel, penable, pwrite, pready   paddr, pwdata / prdata
//
// Five register stages; out_valid rises once the word reaches the fifth stage, and
// one word per cycle is sustained while out_ready stays high. The rate is set by the
// output accumulator loop, a single add and clamp in the last stage.
// arst_n clears the stage valids, the error history and the accumulator, and
// loads the register reset values. A stalled output lets the empty stages
// ahead of it keep filling; in_ready drops only when all five stages hold data.

module incremental_pid_speed_loop_core
	import ipsl_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// input channel
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [IN_W-1:0]    setpoint,
	input  wire logic signed [IN_W-1:0]    measurement,
	// output channel
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [DRIVE_W-1:0]      drive,
	output logic                           saturated,
	// register port
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [ADDR_W-1:0]         paddr,
	input  wire logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]              prdata,
	output logic                           pready
);

	// configuration registers
	logic signed [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [MAG_W-1:0]         out_max_q, i_limit_q;
	logic [SEP_W-1:0]         i_sep_q;

	reg_idx_t reg_idx;
	logic     wr_en;

	// loop state
	logic signed [ERR_W-1:0] e1_q, e2_q;
	logic signed [ACC_W-1:0] acc_q;

	// stage valids and advance terms
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// stage payloads
	logic signed [IN_W-1:0]  sp_s1, ms_s1;
	logic signed [ERR_W-1:0] ie_s2;
	logic signed [D1_W-1:0]  d1_s2;
	logic signed [D2_W-1:0]  d2_s2;
	logic signed [PI_W-1:0]  pi_s3;
	logic signed [PP_W-1:0]  pp_s3;
	logic signed [PD_W-1:0]  pd_s3;
	logic signed [INC_W-1:0] inc_s4;

	// stage logic
	logic signed [ERR_W-1:0] err;
	logic [ERR_W-1:0]        err_mag;
	logic                    sep;
	logic signed [D1_W-1:0]  d1;
	logic signed [D2_W-1:0]  d2;
	logic signed [PI_W-1:0]  ilim, ic;
	logic signed [SUM_W-1:0] olim, sum, sum_cl;
	logic                    sat;
	logic signed [ACC_W-1:0] acc_nx, acc_rnd;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= '0;
			ki_q      <= '0;
			kd_q      <= '0;
			out_max_q <= OUT_MAX_RST;
			i_sep_q   <= '0;
			i_limit_q <= I_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_KP:      kp_q      <= pwdata[GAIN_W-1:0];
				REG_KI:      ki_q      <= pwdata[GAIN_W-1:0];
				REG_KD:      kd_q      <= pwdata[GAIN_W-1:0];
				REG_OUT_MAX: out_max_q <= pwdata[MAG_W-1:0];
				REG_I_SEP:   i_sep_q   <= pwdata[SEP_W-1:0];
				REG_I_LIMIT: i_limit_q <= pwdata[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_KP:      prdata = DATA_W'($unsigned(kp_q));
			REG_KI:      prdata = DATA_W'($unsigned(ki_q));
			REG_KD:      prdata = DATA_W'($unsigned(kd_q));
			REG_OUT_MAX: prdata = DATA_W'(out_max_q);
			REG_I_SEP:   prdata = DATA_W'(i_sep_q);
			REG_I_LIMIT: prdata = DATA_W'(i_limit_q);
			default:     prdata = '0;
		endcase
	end

	// a stage takes a word when it is empty or its word moves on
	assign rdy_s5   = !vld_s5 || out_ready;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign in_ready = !vld_s1 || rdy_s2;
	assign out_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (rdy_s2)   vld_s2 <= vld_s1;
			if (rdy_s3)   vld_s3 <= vld_s2;
			if (rdy_s4)   vld_s4 <= vld_s3;
			if (rdy_s5)   vld_s5 <= vld_s4;
		end
	end

	// stage 2: error, differences, integral separation
	assign err     = ERR_W'(sp_s1) - ERR_W'(ms_s1);
	assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
	assign sep     = (i_sep_q != '0) && (err_mag >= ERR_W'(i_sep_q));
	assign d1      = D1_W'(err) - D1_W'(e1_q);
	assign d2      = D2_W'(err) - (D2_W'(e1_q) <<< 1) + D2_W'(e2_q);

	// stage 4: integral clamp and increment sum
	assign ilim = {{(PI_W-LIM_W){1'b0}}, i_limit_q, {FRAC_BITS{1'b0}}};
	always_comb begin
		if (pi_s3 > ilim)
			ic = ilim;
		else if (pi_s3 < -ilim)
			ic = -ilim;
		else
			ic = pi_s3;
	end

	// stage 5: accumulate, output clamp, truncate toward zero
	assign olim = {{(SUM_W-LIM_W){1'b0}}, out_max_q, {FRAC_BITS{1'b0}}};
	assign sum  = SUM_W'(acc_q) + SUM_W'(inc_s4);
	always_comb begin
		sat    = 1'b1;
		sum_cl = sum;
		if (sum > olim)
			sum_cl = olim;
		else if (sum < -olim)
			sum_cl = -olim;
		else
			sat = 1'b0;
	end
	assign acc_nx  = sum_cl[ACC_W-1:0];
	assign acc_rnd = acc_nx[ACC_W-1] ? (acc_nx + ACC_W'({FRAC_BITS{1'b1}})) : acc_nx;

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q  <= '0;
			e2_q  <= '0;
			acc_q <= '0;
		end else begin
			if (rdy_s2 && vld_s1) begin
				e1_q <= err;
				e2_q <= e1_q;
			end
			if (rdy_s5 && vld_s4)
				acc_q <= acc_nx;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sp_s1 <= setpoint;
			ms_s1 <= measurement;
		end
		if (rdy_s2 && vld_s1) begin
			ie_s2 <= sep ? '0 : err;
			d1_s2 <= d1;
			d2_s2 <= d2;
		end
		if (rdy_s3 && vld_s2) begin
			pi_s3 <= PI_W'(ki_q) * PI_W'(ie_s2);
			pp_s3 <= PP_W'(kp_q) * PP_W'(d1_s2);
			pd_s3 <= PD_W'(kd_q) * PD_W'(d2_s2);
		end
		if (rdy_s4 && vld_s3)
			inc_s4 <= INC_W'(ic) + INC_W'(pp_s3) + INC_W'(pd_s3);
		if (rdy_s5 && vld_s4) begin
			drive     <= acc_rnd[ACC_W-1:FRAC_BITS];
			saturated <= sat;
		end
	end

	// input stalls only with every stage full and the output held
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && out_valid && !out_ready))
		else $error("input stalled with room in the pipeline");

	// error history moves only with a word leaving stage 1
	a_hist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(rdy_s2 && vld_s1) |=> $stable(e1_q) && $stable(e2_q))
		else $error("error history changed without a word");

	// accumulator moves only with a word entering the output stage
	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(rdy_s5 && vld_s4) |=> $stable(acc_q))
		else $error("accumulator changed without a word");

	// a clamped result sits exactly on the output limit
	a_sat_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
			(drive == $signed(DRIVE_W'(out_max_q))) ||
			(drive == -$signed(DRIVE_W'(out_max_q))))
		else $error("saturated word off the output limit");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ipsl_pkg::*;

	localparam int PIPE_LAT    = 5;
	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 200000;

	// addresses past the last register, written to check they are ignored
	localparam reg_idx_t REG_SPARE_A = reg_idx_t'(6);
	localparam reg_idx_t REG_SPARE_B = reg_idx_t'(7);

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      sat;
	} drive_word_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic signed [IN_W-1:0]   setpoint    = '0;
	logic signed [IN_W-1:0]   measurement = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic signed [DRIVE_W-1:0] drive;
	logic                     saturated;
	logic                     psel        = 1'b0;
	logic                     penable     = 1'b0;
	logic                     pwrite      = 1'b0;
	logic [ADDR_W-1:0]        paddr       = '0;
	logic [DATA_W-1:0]        pwdata      = '0;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	// controller shadow: tuning registers and loop state
	logic signed [GAIN_W-1:0] kp_r, ki_r, kd_r;
	logic [MAG_W-1:0]         out_max_r, i_limit_r;
	logic [SEP_W-1:0]         i_sep_r;
	logic signed [ERR_W-1:0]  err1_r, err2_r;
	logic signed [ACC_W-1:0]  acc_r;

	drive_word_t pending_drive[$];
	int          mismatches = 0;
	int          cycle_cnt  = 0;
	bit          bursts_on  = 1'b1;
	bit          long_hold  = 1'b0;
	int          stall_left = 0;
	event        hold_go;

	incremental_pid_speed_loop_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.setpoint   (setpoint),
		.measurement(measurement),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.drive      (drive),
		.saturated  (saturated),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// one velocity-form PID step; updates the shadow state
	function automatic drive_word_t predict_drive(input logic signed [IN_W-1:0] sp,
			input logic signed [IN_W-1:0] ms);
		longint err, mag, integ, prop, deriv, sum, ilim, olim, drv;
		drive_word_t w;
		err = longint'(sp) - longint'(ms);
		mag = (err < 0) ? -err : err;
		// separation kills the integral term on large errors
		if (i_sep_r != 0 && mag >= longint'(i_sep_r))
			integ = 0;
		else
			integ = longint'(ki_r) * err;
		ilim = longint'(i_limit_r) << FRAC_BITS;
		if (integ > ilim)
			integ = ilim;
		else if (integ < -ilim)
			integ = -ilim;
		prop  = longint'(kp_r) * (err - longint'(err1_r));
		deriv = longint'(kd_r) * (err - 2 * longint'(err1_r) + longint'(err2_r));
		sum   = longint'(acc_r) + integ + prop + deriv;
		// output clamp; flag only when strictly beyond the limit
		olim  = longint'(out_max_r) << FRAC_BITS;
		w.sat = 1'b0;
		if (sum > olim) begin
			sum = olim;
			w.sat = 1'b1;
		end else if (sum < -olim) begin
			sum = -olim;
			w.sat = 1'b1;
		end
		acc_r  = sum[ACC_W-1:0];
		err2_r = err1_r;
		err1_r = err[ERR_W-1:0];
		// integer part, truncated toward zero
		drv = (sum < 0) ? -((-sum) >>> FRAC_BITS) : (sum >>> FRAC_BITS);
		w.drive = drv[DRIVE_W-1:0];
		return w;
	endfunction

	// receiver: random stall bursts plus the long hold
	always @(posedge clk) begin
		if (long_hold)
			out_ready <= 1'b0;
		else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (bursts_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	// long receiver hold, counted here
	initial begin
		forever begin
			@(hold_go);
			long_hold = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			long_hold = 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin : chk_blk
		drive_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drive.size() == 0) begin
				$display("%0t: unexpected word drive=%0d saturated=%0b", $time, drive,
						saturated);
				mismatches++;
			end else begin
				w = pending_drive.pop_front();
				if (drive !== w.drive) begin
					$display("%0t: drive expected %0d actual %0d", $time, w.drive, drive);
					mismatches++;
				end
				if (saturated !== w.sat) begin
					$display("%0t: saturated expected %0b actual %0b", $time, w.sat,
							saturated);
					mismatches++;
				end
			end
		end
	end

	// offer one sample word, wait for accept, queue its prediction
	task automatic send_word(input logic signed [IN_W-1:0] sp,
			input logic signed [IN_W-1:0] ms);
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		setpoint    <= sp;
		measurement <= ms;
		do @(posedge clk); while (!in_ready);
		pending_drive.push_back(predict_drive(sp, ms));
	endtask

	// stop offering and let the pipe empty
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_drive.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// register write: setup then access phase
	task automatic cfg_write(input reg_idx_t idx, input int val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= DATA_W'(val[15:0]);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_KP:      kp_r      = val[GAIN_W-1:0];
			REG_KI:      ki_r      = val[GAIN_W-1:0];
			REG_KD:      kd_r      = val[GAIN_W-1:0];
			REG_OUT_MAX: out_max_r = val[MAG_W-1:0];
			REG_I_SEP:   i_sep_r   = val[SEP_W-1:0];
			REG_I_LIMIT: i_limit_r = val[MAG_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic retune(input int kp, input int ki, input int kd, input int omax,
			input int isep, input int ilim);
		wait_drain();
		cfg_write(REG_KP, kp);
		cfg_write(REG_KI, ki);
		cfg_write(REG_KD, kd);
		cfg_write(REG_OUT_MAX, omax);
		cfg_write(REG_I_SEP, isep);
		cfg_write(REG_I_LIMIT, ilim);
	endtask

	function automatic logic signed [IN_W-1:0] near_speed(input int base, input int spread);
		int v;
		v = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return v[IN_W-1:0];
	endfunction

	function automatic logic signed [IN_W-1:0] any_speed();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			default: return IN_W'($urandom());
		endcase
	endfunction

	function automatic int pick_gain();
		case ($urandom_range(0, 9))
			0: return -32768;
			1: return 32767;
			2, 3: return int'($urandom_range(0, 65535)) - 32768;
			default: return int'($urandom_range(0, 1024)) - 512;
		endcase
	endfunction

	function automatic int pick_mag();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32767;
			2: return $urandom_range(0, 200);
			default: return $urandom_range(0, 32767);
		endcase
	endfunction

	function automatic int pick_sep();
		case ($urandom_range(0, 5))
			0, 1, 2: return 0;
			3: return 65535;
			4: return $urandom_range(1, 65535);
			default: return $urandom_range(1, 3000);
		endcase
	endfunction

	// extremes, truncation, separation, both clamps, zero limits, spare addresses
	task automatic test_special_cases();
		wait_drain();
		send_word(0, 0);
		send_word(16'sh7FFF, 16'sh8000);
		send_word(16'sh8000, 16'sh7FFF);
		// half gain: -1.5 must come out as -1
		retune(0, 128, 0, 32767, 0, 32767);
		send_word(-3, 0);
		send_word(3, 0);
		// separation at exactly the threshold and just below it
		retune(0, 256, 0, 32767, 100, 32767);
		send_word(100, 0);
		send_word(0, -99);
		send_word(-100, 0);
		send_word(-99, 0);
		// integral clamp with extreme ki
		retune(0, 32767, 0, 32767, 0, 5);
		send_word(16'sh7FFF, 16'sh8000);
		send_word(16'sh8000, 16'sh7FFF);
		retune(0, -32768, 0, 32767, 0, 5);
		send_word(16'sh7FFF, 16'sh8000);
		// zero output clamp, then exactly at and beyond a clamp of one
		retune(0, 256, 0, 0, 0, 32767);
		send_word(5, 0);
		retune(0, 256, 0, 1, 0, 32767);
		send_word(1, 0);
		send_word(1, 0);
		send_word(-2, 0);
		send_word(-1, 0);
		// zero integral limit
		retune(0, 256, 0, 32767, 0, 0);
		send_word(1000, 0);
		// extreme proportional and derivative gains
		retune(-32768, 0, 32767, 32767, 0, 32767);
		send_word(16'sh7FFF, 16'sh8000);
		send_word(16'sh8000, 16'sh7FFF);
		send_word(0, 0);
		// writes past the register map change nothing
		wait_drain();
		cfg_write(REG_SPARE_A, $urandom());
		cfg_write(REG_SPARE_B, $urandom());
		send_word(123, -45);
	endtask

	// random tunings, mostly tracking a setpoint with noisy feedback
	task automatic test_random_tuning(input int phases, input int per_phase);
		int sp_base;
		for (int ph = 0; ph < phases; ph++) begin
			bursts_on = (ph % 3 != 2);
			retune(pick_gain(), pick_gain(), pick_gain(), pick_mag(), pick_sep(), pick_mag());
			sp_base = int'(any_speed());
			for (int i = 0; i < per_phase; i++) begin
				case ($urandom_range(0, 19))
					0, 1, 2: begin
						// setpoint step
						sp_base = int'(any_speed());
						send_word(sp_base[IN_W-1:0], near_speed(sp_base, 2000));
					end
					3, 4, 5, 6: send_word(any_speed(), any_speed());
					default: send_word(sp_base[IN_W-1:0], near_speed(sp_base, 300));
				endcase
			end
		end
		bursts_on = 1'b1;
	endtask

	// receiver holds long while words keep coming, pipe fills and stalls input
	task automatic test_backpressure();
		retune(pick_gain(), pick_gain(), pick_gain(), 32767, 0, 32767);
		-> hold_go;
		for (int i = 0; i < 24; i++)
			send_word(near_speed(1000, 500), near_speed(900, 500));
		wait_drain();
	endtask

	// back-to-back words with no idling anywhere
	task automatic test_full_rate(input int count);
		retune(pick_gain(), pick_gain(), pick_gain(), pick_mag(), pick_sep(), pick_mag());
		bursts_on = 1'b0;
		for (int i = 0; i < count; i++)
			send_word(any_speed(), any_speed());
		wait_drain();
	endtask

	initial begin
		// shadow reset values
		kp_r      = '0;
		ki_r      = '0;
		kd_r      = '0;
		out_max_r = OUT_MAX_RST;
		i_sep_r   = '0;
		i_limit_r = I_LIMIT_RST;
		err1_r    = '0;
		err2_r    = '0;
		acc_r     = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_random_tuning(8, 64);
		test_backpressure();
		test_full_rate(80);

		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
